>>> src/sfcm_pkg.sv
// Package with shared constants, register codes and colormap coefficients for the false color mapper.
package sfcm_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int COLOR_BITS_DEF    = 8;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int VALUE_FRAC      = 16;
  localparam int NORM_BITS       = 16;
  localparam int ZERO_RANGE_SPAN = 66;
  localparam int COEF_INT_BITS   = 11;
  localparam int POLY_TERMS      = 6;
  localparam int CHANNELS        = 3;

  localparam int MAP_BITS = 3;
  localparam logic [MAP_BITS-1:0] MAP_TURBO       = 3'd0;
  localparam logic [MAP_BITS-1:0] MAP_JET         = 3'd1;
  localparam logic [MAP_BITS-1:0] MAP_VIRIDIS     = 3'd2;
  localparam logic [MAP_BITS-1:0] MAP_GRAY        = 3'd3;
  localparam logic [MAP_BITS-1:0] MAP_CYAN_YELLOW = 3'd4;

  localparam int REG_INDEX_BITS = 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_RANGE_LOW  = 2'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_RANGE_HIGH = 2'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_COLORMAP   = 2'd2;

  // Coefficients in units of 1e-4, lowest power first; the cubic map is padded with zeros.
  localparam int TURBO_TAB [CHANNELS][POLY_TERMS] = '{
    '{1350, 46150, -426600, 1321310, -1529420, 592860},
    '{910, 20860, 40210, -258340, 399950, -193320},
    '{1060, 25320, -11790, -159500, 335040, -172280}
  };
  localparam int VIRIDIS_TAB [CHANNELS][POLY_TERMS] = '{
    '{2777, 1050, -3309, 9850, 0, 0},
    '{54, 14044, -14537, 7180, 0, 0},
    '{3340, 13845, -20906, 10641, 0, 0}
  };

  // Scales a coefficient to the fixed-point format, rounding half away from zero.
  function automatic longint coef_fixed(int k, int fb);
    longint p;
    p = longint'(k) * (longint'(1) <<< fb);
    return (p >= 0) ? (p + 5000) / 10000 : (p - 5000) / 10000;
  endfunction

endpackage

>>> src/scalar_false_color_mapper_unit.sv
// Top level of the scalar false color mapper: range normalization, colormap pipeline and APB registers.
// One sample word enters per clock unless the pipeline is full and stalled. One stage takes the
// word in, one compares it against the range, FRACTION_BITS stages each produce one quotient bit
// of the normalization divide, six stages run the Horner steps of the polynomial maps, and one
// stage clamps and scales the colors.
// A stalled output holds its word while empty stages further up keep filling, so the sample side
// stays ready until the pipeline is full. Configuration may change only while no word is in flight.
module scalar_false_color_mapper_unit #(
  parameter int VALUE_WIDTH   = sfcm_pkg::VALUE_WIDTH_DEF,
  parameter int COLOR_BITS    = sfcm_pkg::COLOR_BITS_DEF,
  parameter int FRACTION_BITS = sfcm_pkg::FRACTION_BITS_DEF,
  localparam int DATA_W   = (VALUE_WIDTH > 32) ? 64 : 32,
  localparam int ADDR_LSB = (VALUE_WIDTH > 32) ? 3 : 2,
  localparam int ADDR_W   = ADDR_LSB + sfcm_pkg::REG_INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [VALUE_WIDTH-1:0] sample_value,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [COLOR_BITS-1:0]         red,
  output logic [COLOR_BITS-1:0]         green,
  output logic [COLOR_BITS-1:0]         blue,
  output logic [sfcm_pkg::NORM_BITS-1:0] normalized
);

  localparam int VW     = VALUE_WIDTH;
  localparam int F      = FRACTION_BITS;
  localparam int ACC_W  = F + sfcm_pkg::COEF_INT_BITS;
  localparam int NT     = sfcm_pkg::POLY_TERMS;
  localparam int NC     = sfcm_pkg::CHANNELS;
  localparam int NB     = sfcm_pkg::NORM_BITS;
  localparam int ST_SAT = 1;
  localparam int ST_DIV = 2;
  localparam int ST_P0  = ST_DIV + F;
  localparam int ST_OUT = ST_P0 + NT;
  localparam int NS     = ST_OUT + 1;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;
  localparam logic [COLOR_BITS-1:0] CMAX = {COLOR_BITS{1'b1}};

  logic signed [VW-1:0] range_low;
  logic signed [VW-1:0] range_high;
  logic [sfcm_pkg::MAP_BITS-1:0] colormap_select;
  logic [sfcm_pkg::REG_INDEX_BITS-1:0] reg_index;
  logic cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:ADDR_LSB];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_low       <= '0;
      range_high      <= VW'(1) << sfcm_pkg::VALUE_FRAC;
      colormap_select <= sfcm_pkg::MAP_JET;
    end else if (cfg_write) begin
      unique case (reg_index)
        sfcm_pkg::REG_RANGE_LOW:  range_low <= pwdata[VW-1:0];
        sfcm_pkg::REG_RANGE_HIGH: range_high <= pwdata[VW-1:0];
        sfcm_pkg::REG_COLORMAP:   colormap_select <= pwdata[sfcm_pkg::MAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      sfcm_pkg::REG_RANGE_LOW:  prdata = DATA_W'(range_low);
      sfcm_pkg::REG_RANGE_HIGH: prdata = DATA_W'(range_high);
      sfcm_pkg::REG_COLORMAP:   prdata = DATA_W'(colormap_select);
      default:                  prdata = '0;
    endcase
  end

  // Ordered range ends and span, refreshed every cycle from the registers.
  logic signed [VW-1:0] lo_r;
  logic signed [VW:0]   hi_r;
  logic [VW-1:0]        span_r;
  logic signed [VW-1:0] lo_next;
  logic signed [VW:0]   hi_next;

  always_comb begin
    lo_next = (range_low < range_high) ? range_low : range_high;
    hi_next = (range_low < range_high) ? (VW + 1)'(range_high) : (VW + 1)'(range_low);
    if (range_low == range_high) begin
      hi_next = (VW + 1)'(lo_next) + (VW + 1)'(sfcm_pkg::ZERO_RANGE_SPAN);
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_next;
    hi_r   <= hi_next;
    span_r <= VW'(hi_next - (VW + 1)'(lo_next));
  end

  // Stall chain: a stage loads when it is empty or its successor moves on.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || result_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign sample_ready = en[0];
  assign result_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  logic signed [VW-1:0] in_v;
  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_v <= sample_value;
    end
  end

  logic [VW-1:0] sat_rem;
  logic          sat_lo;
  logic          sat_hi;
  always_ff @(posedge clk) begin
    if (en[ST_SAT]) begin
      sat_lo  <= in_v <= lo_r;
      sat_hi  <= (VW + 1)'(in_v) >= hi_r;
      sat_rem <= VW'(in_v - lo_r);
    end
  end

  logic [VW-1:0] div_rem [F];
  logic [F-1:0]  div_q   [F];
  logic          div_lo  [F];
  logic          div_hi  [F];

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [VW-1:0] rem_in;
    logic [F-1:0]  q_in;
    logic          lo_in;
    logic          hi_in;
    logic [VW:0]   rem2;
    logic          geq;

    if (k == 0) begin : g_first
      assign rem_in = sat_rem;
      assign q_in   = '0;
      assign lo_in  = sat_lo;
      assign hi_in  = sat_hi;
    end else begin : g_rest
      assign rem_in = div_rem[k-1];
      assign q_in   = div_q[k-1];
      assign lo_in  = div_lo[k-1];
      assign hi_in  = div_hi[k-1];
    end

    assign rem2 = {rem_in, 1'b0};
    assign geq  = rem2 >= {1'b0, span_r};

    always_ff @(posedge clk) begin
      if (en[ST_DIV+k]) begin
        div_rem[k] <= geq ? VW'(rem2 - {1'b0, span_r}) : rem2[VW-1:0];
        div_q[k]   <= (q_in << 1) | F'(geq);
        div_lo[k]  <= lo_in;
        div_hi[k]  <= hi_in;
      end
    end
  end

  // Coefficients for the selected map; non-polynomial maps ignore them.
  logic signed [ACC_W-1:0] coef [NC][NT];
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      for (int i = 0; i < NT; i++) begin
        if (colormap_select == sfcm_pkg::MAP_VIRIDIS) begin
          coef[c][i] = ACC_W'(sfcm_pkg::coef_fixed(sfcm_pkg::VIRIDIS_TAB[c][i], F));
        end else begin
          coef[c][i] = ACC_W'(sfcm_pkg::coef_fixed(sfcm_pkg::TURBO_TAB[c][i], F));
        end
      end
    end
  end

  logic [F:0]              p_t   [NT];
  logic signed [ACC_W-1:0] p_acc [NT][NC];

  logic [F:0] t_next;
  assign t_next = div_lo[F-1] ? '0 : (div_hi[F-1] ? ONE : {1'b0, div_q[F-1]});

  always_ff @(posedge clk) begin
    if (en[ST_P0]) begin
      p_t[0] <= t_next;
      for (int c = 0; c < NC; c++) begin
        p_acc[0][c] <= coef[c][NT-1];
      end
    end
  end

  for (genvar j = 1; j < NT; j++) begin : g_horner
    for (genvar c = 0; c < NC; c++) begin : g_ch
      logic signed [ACC_W+F+1:0] prod;
      logic signed [ACC_W+F+1:0] shifted;
      assign prod    = p_acc[j-1][c] * $signed({1'b0, p_t[j-1]});
      assign shifted = prod >>> F;
      always_ff @(posedge clk) begin
        if (en[ST_P0+j]) begin
          p_acc[j][c] <= shifted[ACC_W-1:0] + coef[c][NT-1-j];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en[ST_P0+j]) begin
        p_t[j] <= p_t[j-1];
      end
    end
  end

  function automatic logic [COLOR_BITS-1:0] to_color(logic signed [ACC_W-1:0] c);
    logic [F:0]              cl;
    logic [F+COLOR_BITS:0]   sc;
    if (c < 0) begin
      cl = '0;
    end else if (c > $signed(ACC_W'(ONE))) begin
      cl = ONE;
    end else begin
      cl = c[F:0];
    end
    sc = (F + COLOR_BITS + 1)'(cl) * (F + COLOR_BITS + 1)'(CMAX);
    return sc[F+COLOR_BITS-1:F];
  endfunction

  logic [F:0]              t_f;
  logic signed [ACC_W-1:0] ts;
  logic signed [ACC_W-1:0] one_s;
  logic signed [ACC_W-1:0] dev;
  logic signed [ACC_W-1:0] ch_r;
  logic signed [ACC_W-1:0] ch_g;
  logic signed [ACC_W-1:0] ch_b;
  logic [NB:0]             nrm_full;

  assign t_f   = p_t[NT-1];
  assign ts    = ACC_W'(t_f);
  assign one_s = ACC_W'(ONE);

  always_comb begin
    dev = (ts <<< 1) - one_s;
    if (dev < 0) begin
      dev = -dev;
    end
    unique case (colormap_select)
      sfcm_pkg::MAP_JET: begin
        ch_r = (3 * ts - one_s) >>> 1;
        ch_g = ((3 * one_s) >>> 1) - dev;
        ch_b = (3 * (one_s - ts) - one_s) >>> 1;
      end
      sfcm_pkg::MAP_GRAY: begin
        ch_r = ts;
        ch_g = ts;
        ch_b = ts;
      end
      sfcm_pkg::MAP_CYAN_YELLOW: begin
        ch_r = ts;
        ch_g = one_s;
        ch_b = one_s - ts;
      end
      default: begin
        ch_r = p_acc[NT-1][0];
        ch_g = p_acc[NT-1][1];
        ch_b = p_acc[NT-1][2];
      end
    endcase
  end

  if (F >= NB) begin : g_nrm_shr
    assign nrm_full = (NB + 1)'(t_f >> (F - NB));
  end else begin : g_nrm_shl
    assign nrm_full = (NB + 1)'(t_f) << (NB - F);
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      red        <= to_color(ch_r);
      green      <= to_color(ch_g);
      blue       <= to_color(ch_b);
      normalized <= nrm_full[NB] ? {NB{1'b1}} : nrm_full[NB-1:0];
    end
  end

endmodule

>>> src/sfcm_checker.sv
// Port-level checker for the false color mapper and its bind to the top level.
module sfcm_checker #(
  parameter int COLOR_BITS = sfcm_pkg::COLOR_BITS_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           sample_valid,
  input logic                           sample_ready,
  input logic                           result_valid,
  input logic                           result_ready,
  input logic [COLOR_BITS-1:0]          red,
  input logic [COLOR_BITS-1:0]          green,
  input logic [COLOR_BITS-1:0]          blue,
  input logic [sfcm_pkg::NORM_BITS-1:0] normalized
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word valid right after reset");

  // An empty output stage means the whole pipeline can move, so samples are taken.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample side stalled while no result word is waiting");

  // An offered but blocked sample means the output is full and stalled.
  a_stall_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_ready |-> result_valid && !result_ready)
    else $error("sample side stalled without a blocked result word");

  // A stalled result word keeps its value.
  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(normalized))
    else $error("stalled result word changed");

endmodule

bind scalar_false_color_mapper_unit sfcm_checker #(.COLOR_BITS(COLOR_BITS)) u_sfcm_checker (
  .clk(clk),
  .rst(rst),
  .sample_valid(sample_valid),
  .sample_ready(sample_ready),
  .result_valid(result_valid),
  .result_ready(result_ready),
  .red(red),
  .green(green),
  .blue(blue),
  .normalized(normalized)
);

>>> test/scalar_false_color_mapper_unit_test.sv
// Testbench for the scalar false color mapper: directed and random samples checked by a predictor.
module scalar_false_color_mapper_unit_test;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] normalized;
  } color_word_t;

  typedef struct {
    logic signed [31:0] sample;
    bit                 known;
    color_word_t        color;
  } stim_row_t;

  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic signed [31:0] sample_value = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [7:0] red, green, blue;
  logic [15:0] normalized;

  scalar_false_color_mapper_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longint cfg_low = 0;
  longint cfg_high = 65536;
  logic [2:0] cfg_map = sfcm_pkg::MAP_JET;
  color_word_t expected_colors[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint floor_frac(longint p);
    return p >>> 16;
  endfunction

  function automatic longint coef_q(int k);
    longint p;
    p = longint'(k) * 65536;
    return (p >= 0) ? (p + 5000) / 10000 : (p - 5000) / 10000;
  endfunction

  function automatic longint horner(int tab[6], int n, longint t);
    longint acc;
    acc = coef_q(tab[n-1]);
    for (int i = n - 2; i >= 0; i--) acc = floor_frac(acc * t) + coef_q(tab[i]);
    return acc;
  endfunction

  function automatic logic [7:0] channel_byte(longint c);
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    return 8'((c * 255) >> 16);
  endfunction

  function automatic color_word_t map_sample(longint v);
    longint lo, hi, t, r, g, b, d;
    int tb0[6], tb1[6], tb2[6], vr0[6], vr1[6], vr2[6];
    color_word_t w;
    tb0 = '{1350, 46150, -426600, 1321310, -1529420, 592860};
    tb1 = '{910, 20860, 40210, -258340, 399950, -193320};
    tb2 = '{1060, 25320, -11790, -159500, 335040, -172280};
    vr0 = '{2777, 1050, -3309, 9850, 0, 0};
    vr1 = '{54, 14044, -14537, 7180, 0, 0};
    vr2 = '{3340, 13845, -20906, 10641, 0, 0};
    lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
    hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
    if (hi == lo) hi = lo + 66;
    if (v <= lo) t = 0;
    else if (v >= hi) t = 65536;
    else t = ((v - lo) * 65536) / (hi - lo);
    case (cfg_map)
      sfcm_pkg::MAP_JET: begin
        d = 2 * t - 65536;
        if (d < 0) d = -d;
        r = (3 * t - 65536) >>> 1;
        g = ((3 * 65536) >>> 1) - d;
        b = (3 * (65536 - t) - 65536) >>> 1;
      end
      sfcm_pkg::MAP_VIRIDIS: begin
        r = horner(vr0, 4, t);
        g = horner(vr1, 4, t);
        b = horner(vr2, 4, t);
      end
      sfcm_pkg::MAP_GRAY: begin
        r = t;
        g = t;
        b = t;
      end
      sfcm_pkg::MAP_CYAN_YELLOW: begin
        r = t;
        g = 65536;
        b = 65536 - t;
      end
      default: begin
        r = horner(tb0, 6, t);
        g = horner(tb1, 6, t);
        b = horner(tb2, 6, t);
      end
    endcase
    w.red = channel_byte(r);
    w.green = channel_byte(g);
    w.blue = channel_byte(b);
    w.normalized = (t > 65535) ? 16'hFFFF : 16'(t);
    return w;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      sfcm_pkg::REG_RANGE_LOW: cfg_low = longint'($signed(value));
      sfcm_pkg::REG_RANGE_HIGH: cfg_high = longint'($signed(value));
      sfcm_pkg::REG_COLORMAP: cfg_map = value[2:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(logic signed [31:0] v);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_value <= v;
    expected_colors.push_back(map_sample(longint'(v)));
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic signed [31:0] random_sample();
    longint lo, hi, span;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'sh7FFFFFFF;
      2: return 32'sh80000000;
      default: begin
        lo = (cfg_low < cfg_high) ? cfg_low : cfg_high;
        hi = (cfg_low < cfg_high) ? cfg_high : cfg_low;
        span = hi - lo + 4;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        return 32'(lo - 2 + longint'($urandom_range(32'(span))));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    color_word_t got, want;
    if (!rst) begin
      result_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      if (result_valid && result_ready) begin
        got = '{red, green, blue, normalized};
        if (expected_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected color word %h", got);
        end else begin
          want = expected_colors.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %h, got %h", want, got);
          end
        end
      end
    end
  end

  stim_row_t directed[] = '{
    '{32'sd0,      1'b1, '{8'd0, 8'd127, 8'd255, 16'd0}},
    '{32'sd65536,  1'b1, '{8'd255, 8'd127, 8'd0, 16'hFFFF}},
    '{32'sh7FFFFFFF, 1'b1, '{8'd255, 8'd127, 8'd0, 16'hFFFF}},
    '{32'sh80000000, 1'b1, '{8'd0, 8'd127, 8'd255, 16'd0}},
    '{32'sd32768,  1'b0, '{8'd0, 8'd0, 8'd0, 16'd0}},
    '{32'sd16384,  1'b0, '{8'd0, 8'd0, 8'd0, 16'd0}},
    '{32'sd65535,  1'b0, '{8'd0, 8'd0, 8'd0, 16'd0}},
    '{-32'sd1,     1'b0, '{8'd0, 8'd0, 8'd0, 16'd0}}
  };

  int phase_idle[4] = '{0, 77, 0, 10};
  int phase_stall[4] = '{0, 0, 77, 10};

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].known && map_sample(longint'(directed[i].sample)) !== directed[i].color) begin
        mismatches++;
        $display("predictor disagrees on directed row %0d", i);
      end
      send_sample(directed[i].sample);
    end
    drain();
    for (logic [3:0] m = 0; m < 8; m++) begin
      write_reg(sfcm_pkg::REG_COLORMAP, {29'h1ABCDEF0, m[2:0]});
      foreach (directed[i]) send_sample(directed[i].sample);
      drain();
    end
    write_reg(sfcm_pkg::REG_RANGE_LOW, 32'h0001_0000);
    write_reg(sfcm_pkg::REG_RANGE_HIGH, 32'h0001_0000);
    for (int i = -2; i < 70; i += 7) send_sample(32'sh0001_0000 + i);
    drain();
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    for (int p = 0; p < 12; p++) begin
      send_idle_pct = phase_idle[p % 4];
      recv_stall_pct = phase_stall[p % 4];
      case (p % 6)
        0: begin
          write_reg(sfcm_pkg::REG_RANGE_LOW, 32'h8000_0000);
          write_reg(sfcm_pkg::REG_RANGE_HIGH, 32'h7FFF_FFFF);
        end
        1: begin
          write_reg(sfcm_pkg::REG_RANGE_LOW, 32'h0005_0000);
          write_reg(sfcm_pkg::REG_RANGE_HIGH, 32'hFFFB_0000);
        end
        2: begin
          write_reg(sfcm_pkg::REG_RANGE_LOW, $urandom);
          write_reg(sfcm_pkg::REG_RANGE_HIGH, $urandom);
        end
        3: begin
          write_reg(sfcm_pkg::REG_RANGE_LOW, 32'(-$urandom_range(1000)));
          write_reg(sfcm_pkg::REG_RANGE_HIGH, 32'($urandom_range(300000)));
        end
        4: begin
          write_reg(sfcm_pkg::REG_RANGE_LOW, 32'h7FFF_FFFF);
          write_reg(sfcm_pkg::REG_RANGE_HIGH, 32'h7FFF_FFFF);
        end
        default: begin
          write_reg(sfcm_pkg::REG_RANGE_LOW, 32'h0000_0000);
          write_reg(sfcm_pkg::REG_RANGE_HIGH, 32'h0000_0100);
        end
      endcase
      write_reg(sfcm_pkg::REG_COLORMAP, $urandom_range(7));
      repeat (80) send_sample(random_sample());
      drain();
    end
    if (mismatches == 0 && expected_colors.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
src/sfcm_pkg.sv
src/scalar_false_color_mapper_unit.sv
src/sfcm_checker.sv
test/scalar_false_color_mapper_unit_test.sv
